FILE: hw/rtl/ple_pkg.sv
// Package for the positional list engine.
// Holds the action and status codes and the control struct shared by the cells.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

	localparam int WORD_W   = 32;
	localparam int POS_W    = 7;
	localparam int LEN_W    = 7;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_READ   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_READ_RANGE = 3'd1,
		ST_BAD_INSERT = 3'd2,
		ST_BAD_DELETE = 3'd3,
		ST_FULL       = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2
	} cell_op_t;

	// Broadcast to every cell of the chain in each cycle.
	typedef struct packed {
		cell_op_t                 op;
		logic signed [WORD_W-1:0] word;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/ple_cell.sv
// One storage cell of the positional list chain.
// Holds one entry; takes the new word or its left/right neighbor's on insert/delete.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_cell
	import ple_pkg::*;
#(
	parameter int AXW   = 7,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic [AXW-1:0]           at,
	input  logic signed [WORD_W-1:0] left,
	input  logic signed [WORD_W-1:0] right,
	output logic signed [WORD_W-1:0] entry,
	output logic                     hit
);

	localparam logic [AXW-1:0] MY_INDEX = AXW'(INDEX);

	logic signed [WORD_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (MY_INDEX == at) begin
					entry_q <= ctrl.word;
				end else if (MY_INDEX > at) begin
					entry_q <= left;
				end
			end
			CELL_DELETE: begin
				if (MY_INDEX >= at) begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign hit   = (MY_INDEX == at);

endmodule

FILE: hw/rtl/positional_list_engine.sv
// Positional list engine: an ordered list of up to CAPACITY signed words.
// Throughput: one item per cycle unless a waiting result stalls the input; each
// result is registered; the cells at or past the target shift in the same cycle.
// Reset: arst_n clears the entry count and the output valid flag; entries are
// not cleared and are only read after they have been written.
`timescale 1ns / 1ps

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ACTION_W-1:0]        action,
	input  logic [POS_W-1:0]           position,
	input  logic signed [WORD_W-1:0]   value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic signed [WORD_W-1:0]   read_value,
	output logic [LEN_W-1:0]           list_length
);

	// Width of the entry count, of a cell index, and of the compare datapath.
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int AW  = $clog2(CAPACITY);
	localparam int AXW = (AW > POS_W) ? AW : POS_W;
	localparam int W   = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CW-1:0]            count_q;
	logic                     out_valid_q;
	status_t                  status_q;
	logic signed [WORD_W-1:0] read_value_q;
	logic [LEN_W-1:0]         list_length_q;

	logic                     accept;
	cell_ctrl_t               ctrl;
	logic [AXW-1:0]           at;
	logic [W-1:0]             pos_w;
	logic [W-1:0]             cnt_w;
	logic [W-1:0]             cnt_next_w;
	status_t                  status_d;
	logic signed [WORD_W-1:0] read_d;
	logic signed [WORD_W-1:0] selected;

	logic signed [WORD_W-1:0] cell_entry [CAPACITY];
	logic                     cell_hit   [CAPACITY];

	// The input side is held off only while a finished result waits downstream.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign pos_w = W'(position);
	assign cnt_w = W'(count_q);
	// Zero-based target cell; position zero wraps but is never used for a move.
	assign at    = AXW'(position - POS_W'(1));

	// The cells drive their entries out; the one whose index matches the target
	// shows up on the read bus, the rest are masked.
	always_comb begin
		selected = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_hit[i]) begin
				selected = selected | cell_entry[i];
			end
		end
	end

	// Decode the item into a status, a read word, a new count and a cell command.
	always_comb begin
		status_d   = ST_OK;
		read_d     = '0;
		cnt_next_w = cnt_w;
		ctrl.op    = CELL_HOLD;
		ctrl.word  = value;
		unique case (action_t'(action))
			ACT_READ: begin
				if (pos_w == '0) begin
					read_d = -32'sd1;
				end else if (pos_w > cnt_w) begin
					status_d = ST_READ_RANGE;
				end else begin
					read_d = selected;
				end
			end
			ACT_INSERT: begin
				if (pos_w == '0 || pos_w > cnt_w + W'(1)) begin
					status_d = ST_BAD_INSERT;
				end else if (cnt_w >= W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					cnt_next_w = cnt_w + W'(1);
					ctrl.op    = accept ? CELL_INSERT : CELL_HOLD;
				end
			end
			ACT_DELETE: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					status_d = ST_BAD_DELETE;
				end else begin
					cnt_next_w = cnt_w - W'(1);
					ctrl.op    = accept ? CELL_DELETE : CELL_HOLD;
				end
			end
			default: begin
			end
		endcase
	end

	// The chain: each cell sees its left and right neighbor. The ends take
	// nothing meaningful, since no live entry is ever moved in from there.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [WORD_W-1:0] left_in;
		logic signed [WORD_W-1:0] right_in;

		if (g == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = cell_entry[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_mid_r
			assign right_in = cell_entry[g+1];
		end

		ple_cell #(
			.AXW   (AXW),
			.INDEX (g)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.at    (at),
			.left  (left_in),
			.right (right_in),
			.entry (cell_entry[g]),
			.hit   (cell_hit[g])
		);
	end

	// Control state: the entry count and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= CW'(cnt_next_w);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, loaded whenever an item is accepted.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			read_value_q  <= read_d;
			list_length_q <= cnt_next_w[LEN_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign list_length = list_length_q;

endmodule

FILE: hw/rtl/ple_checker.sv
// Port-level checks for the positional list engine, and the bind that attaches them.
// Depends on ple_pkg and on the ports of positional_list_engine.
`timescale 1ns / 1ps

module ple_checker
	import ple_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [STATUS_W-1:0]      status,
	input logic signed [WORD_W-1:0] read_value,
	input logic [LEN_W-1:0]         list_length
);

	localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

	// A held result stays put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
		&& $stable(read_value) && $stable(list_length))
		else $error("held result changed");

	// The input is held off only by a waiting result.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// An accepted item always gives a result in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted item gave no result");

	// A full status only comes with a full list.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> list_length == FULL_LEN)
		else $error("full status with a list that is not full");

	// Failed items return no data.
	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_value == '0)
		else $error("error status with nonzero read data");

endmodule

bind positional_list_engine ple_checker #(
	.CAPACITY (CAPACITY)
) u_ple_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.read_value  (read_value),
	.list_length (list_length)
);
